// File: src/psp_pkg.sv
// package for the priority slice picker
// holds field widths, op and status codes, priority limits, and the token and result types
// no dependencies
`timescale 1ns / 1ps

package psp_pkg;

  // payload field widths
  localparam int OP_W   = 3;
  localparam int SLOT_W = 6;
  localparam int PRIO_W = 7;
  localparam int STAT_W = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_RUN    = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd3;
  localparam logic [OP_W-1:0] OP_SETPRI = 3'd4;
  localparam logic [OP_W-1:0] OP_PICK   = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE  = 2'd2;

  // priority limits
  localparam logic [PRIO_W-1:0] PRIO_MAX   = 7'd100;
  localparam logic [PRIO_W-1:0] PRIO_RESET = 7'd60;

  // token walking down the cell row (fixed-width part)
  typedef struct packed {
    logic              vld;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] np;
    logic              hit;
    logic [PRIO_W-1:0] old;
    logic              any;
    logic [PRIO_W-1:0] bprio;
  } psp_tok_t;

  // one result item
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] chosen_slot;
    logic [PRIO_W-1:0] old_priority;
    logic [STAT_W-1:0] status;
  } psp_res_t;

endpackage

// File: src/psp_in_if.sv
// input channel: one op per transfer
// depends on psp_pkg for field widths
`timescale 1ns / 1ps

interface psp_in_if;
  logic                      valid;
  logic                      ready;
  logic [psp_pkg::OP_W-1:0]   op;
  logic [psp_pkg::SLOT_W-1:0] slot;
  logic [psp_pkg::PRIO_W-1:0] req_prio;

  modport source (output valid, output op, output slot, output req_prio, input ready);
  modport sink   (input valid, input op, input slot, input req_prio, output ready);
endinterface

// File: src/psp_out_if.sv
// result channel: one result per transfer
// depends on psp_pkg for field widths
`timescale 1ns / 1ps

interface psp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [psp_pkg::SLOT_W-1:0] chosen_slot;
  logic [psp_pkg::PRIO_W-1:0] old_priority;
  logic [psp_pkg::STAT_W-1:0] status;

  modport source (output valid, output found, output chosen_slot, output old_priority,
                  output status, input ready);
  modport sink   (input valid, input found, input chosen_slot, input old_priority,
                  input status, output ready);
endinterface

// File: src/psp_cfg_if.sv
// configuration write channel for the initial priority register
// depends on psp_pkg for the data width
`timescale 1ns / 1ps

interface psp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [psp_pkg::PRIO_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/psp_cell.sv
// one task slot of the scheduler row; applies the passing token and forwards it
// depends on psp_pkg
`timescale 1ns / 1ps

module psp_cell #(
  parameter int SLOTS      = 64,
  parameter int SLICE_BITS = 16,
  parameter int SLOT_IDX   = 0,
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [psp_pkg::PRIO_W-1:0] init_prio,
  input  psp_pkg::psp_tok_t          tok_i,
  input  logic [SLICE_BITS-1:0]      bsl_i,
  input  logic [IDX_W-1:0]           bidx_i,
  input  logic                       commit_vld,
  input  logic [IDX_W-1:0]           commit_idx,
  output psp_pkg::psp_tok_t          tok_o,
  output logic [SLICE_BITS-1:0]      bsl_o,
  output logic [IDX_W-1:0]           bidx_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_IDX);

  logic                       used_r, used_nxt;
  logic                       run_r, run_nxt;
  logic [psp_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [SLICE_BITS-1:0]      sl_r, sl_nxt;
  psp_pkg::psp_tok_t          tok_r, tok_nxt;
  logic [SLICE_BITS-1:0]      bsl_r, bsl_nxt;
  logic [IDX_W-1:0]           bidx_r, bidx_nxt;
  logic                       match;
  logic                       better;

  assign match = ({{(32 - psp_pkg::SLOT_W){1'b0}}, tok_i.slot} == 32'(SLOT_IDX));

  // pick comparison: lower priority, then fewer slices, earlier index already kept
  assign better = used_r && run_r &&
                  (!tok_i.any || (prio_r < tok_i.bprio) ||
                   ((prio_r == tok_i.bprio) && (sl_r < bsl_i)));

  // op decode for this slot and token update
  always_comb begin
    used_nxt = used_r;
    run_nxt  = run_r;
    prio_nxt = prio_r;
    sl_nxt   = sl_r;
    tok_nxt  = tok_i;
    bsl_nxt  = bsl_i;
    bidx_nxt = bidx_i;
    if (tok_i.vld) begin
      case (tok_i.op)
        psp_pkg::OP_ALLOC: begin
          if (match) begin
            used_nxt    = 1'b1;
            run_nxt     = 1'b0;
            prio_nxt    = init_prio;
            sl_nxt      = '0;
            tok_nxt.hit = 1'b1;
          end
        end
        psp_pkg::OP_RUN: begin
          if (match && used_r) begin
            run_nxt     = 1'b1;
            tok_nxt.hit = 1'b1;
          end
        end
        psp_pkg::OP_STOP: begin
          if (match && used_r) begin
            run_nxt     = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        psp_pkg::OP_FREE: begin
          if (match && used_r) begin
            run_nxt     = 1'b0;
            used_nxt    = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        psp_pkg::OP_SETPRI: begin
          if (match && used_r && (tok_i.np <= psp_pkg::PRIO_MAX)) begin
            tok_nxt.old = prio_r;
            prio_nxt    = tok_i.np;
            if (prio_r != tok_i.np) begin
              sl_nxt = '0;
            end
            tok_nxt.hit = 1'b1;
          end
        end
        psp_pkg::OP_PICK: begin
          if (better) begin
            tok_nxt.any   = 1'b1;
            tok_nxt.bprio = prio_r;
            bsl_nxt       = sl_r;
            bidx_nxt      = MY_IDX;
          end
        end
        default: begin
        end
      endcase
    end else if (commit_vld && (commit_idx == MY_IDX)) begin
      // winner of a pick: one more slice, saturating, and off the run list
      run_nxt = 1'b0;
      if (sl_r != {SLICE_BITS{1'b1}}) begin
        sl_nxt = sl_r + 1'b1;
      end
    end
  end

  // slot state and token stage
  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    sl_r   <= sl_nxt;
    bsl_r  <= bsl_nxt;
    bidx_r <= bidx_nxt;
    if (!rst_n) begin
      used_r <= 1'b0;
      run_r  <= 1'b0;
      tok_r  <= '0;
    end else begin
      used_r <= used_nxt;
      run_r  <= run_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign bsl_o  = bsl_r;
  assign bidx_o = bidx_r;

endmodule

// File: src/priority_slice_picker_top.sv
// top level of the priority slice picker: cell row, sequencer and channel registers
// depends on psp_pkg, psp_in_if, psp_out_if, psp_cfg_if and psp_cell
//
//   channel  | dir | payload                                        | role
//   cfg_ch   | in  | data                                           | initial priority write
//   in_ch    | in  | op, slot, req_prio                             | one op per transfer
//   out_ch   | out | found, chosen_slot, old_priority, status       | one result per op
//
// every op walks a token through the row of SLOTS cells, one cell per cycle; the result
// at the end of the row is registered in pend_r and then moved into the output register,
// and in_ch.ready returns in the same cycle that the result there becomes valid
// one item is in flight at a time; in_ch.ready is high only while the row is empty
// a stalled result is held in the output register until out_ch.ready; the next op
// is not taken until the result has moved into that register
// synchronous active-low reset clears all used and runnable flags; cfg_ch is always ready
`timescale 1ns / 1ps

module priority_slice_picker_top #(
  parameter int SLOTS      = 64,
  parameter int SLICE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  psp_cfg_if.sink   cfg_ch,
  psp_in_if.sink    in_ch,
  psp_out_if.source out_ch
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [psp_pkg::PRIO_W-1:0] init_prio_r;
  psp_pkg::psp_res_t          pend_r, pend_nxt;
  psp_pkg::psp_res_t          out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;
  psp_pkg::psp_res_t          res;
  logic                       in_xfer;
  logic                       commit_vld;

  psp_pkg::psp_tok_t          tok   [SLOTS+1];
  logic [SLICE_BITS-1:0]      bsl   [SLOTS+1];
  logic [IDX_W-1:0]           bidx  [SLOTS+1];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // token launched into the first cell on an input transfer
  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = in_xfer;
    tok[0].op    = in_ch.op;
    tok[0].slot  = in_ch.slot;
    tok[0].np    = in_ch.req_prio;
    bsl[0]       = '0;
    bidx[0]      = '0;
  end

  // row of slot cells
  for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
    psp_cell #(
      .SLOTS      (SLOTS),
      .SLICE_BITS (SLICE_BITS),
      .SLOT_IDX   (gi)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .init_prio  (init_prio_r),
      .tok_i      (tok[gi]),
      .bsl_i      (bsl[gi]),
      .bidx_i     (bidx[gi]),
      .commit_vld (commit_vld),
      .commit_idx (bidx[SLOTS]),
      .tok_o      (tok[gi+1]),
      .bsl_o      (bsl[gi+1]),
      .bidx_o     (bidx[gi+1])
    );
  end

  // winner update broadcast as the pick token leaves the row
  assign commit_vld = tok[SLOTS].vld && (tok[SLOTS].op == psp_pkg::OP_PICK) && tok[SLOTS].any;

  // result from the token at the end of the row
  always_comb begin
    res = '0;
    case (tok[SLOTS].op)
      psp_pkg::OP_ALLOC, psp_pkg::OP_RUN, psp_pkg::OP_STOP, psp_pkg::OP_FREE: begin
        if (tok[SLOTS].hit) begin
          res.found = 1'b1;
        end else begin
          res.status = psp_pkg::ST_NONE;
        end
      end
      psp_pkg::OP_SETPRI: begin
        if (tok[SLOTS].np > psp_pkg::PRIO_MAX) begin
          res.status = psp_pkg::ST_RANGE;
        end else if (tok[SLOTS].hit) begin
          res.found        = 1'b1;
          res.old_priority = tok[SLOTS].old;
        end else begin
          res.status = psp_pkg::ST_NONE;
        end
      end
      psp_pkg::OP_PICK: begin
        if (tok[SLOTS].any) begin
          res.found       = 1'b1;
          res.chosen_slot = psp_pkg::SLOT_W'(bidx[SLOTS]);
        end else begin
          res.status = psp_pkg::ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (tok[SLOTS].vld) begin
          pend_nxt  = res;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      init_prio_r <= psp_pkg::PRIO_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // initial priority write, clamped to the top of the range
      if (cfg_ch.valid && cfg_ch.ready) begin
        init_prio_r <= (cfg_ch.data > psp_pkg::PRIO_MAX) ? psp_pkg::PRIO_MAX : cfg_ch.data;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_r.found;
  assign out_ch.chosen_slot  = out_r.chosen_slot;
  assign out_ch.old_priority = out_r.old_priority;
  assign out_ch.status       = out_r.status;

endmodule

// File: tb/testbench.sv
// self-checking testbench for priority_slice_picker_top
// depends on psp_pkg, psp_in_if, psp_out_if, psp_cfg_if and the block's sources
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT = 64;
  localparam int PRIO_NONE = 101;
  localparam logic [15:0] SLICE_TOP = 16'hFFFF;
  localparam int PHASE_OPS = 275;
  localparam int NPHASE = 6;

  // slot table model and queue of awaited results
  class sched_board;
    bit                         used [NSLOT];
    bit                         runnable [NSLOT];
    logic [psp_pkg::PRIO_W-1:0] prio [NSLOT];
    logic [15:0]                slices [NSLOT];
    logic [psp_pkg::PRIO_W-1:0] init_prio;
    psp_pkg::psp_res_t          awaited_res [$];
    int                         errors;
    int                         ops_seen;
    int                         checked;
    int                         picks_hit;
    int                         range_rejects;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        used[i] = 1'b0;
        runnable[i] = 1'b0;
        prio[i] = '0;
        slices[i] = '0;
      end
      init_prio = psp_pkg::PRIO_RESET;
      errors = 0;
      ops_seen = 0;
      checked = 0;
      picks_hit = 0;
      range_rejects = 0;
    endfunction

    // register write, clamped to the priority range
    function void set_initial(logic [psp_pkg::PRIO_W-1:0] v);
      init_prio = (v > psp_pkg::PRIO_MAX) ? psp_pkg::PRIO_MAX : v;
    endfunction

    function int pending();
      return awaited_res.size();
    endfunction

    // apply one accepted op to the table and queue its result
    function void note_op(logic [psp_pkg::OP_W-1:0] op, logic [psp_pkg::SLOT_W-1:0] s,
                          logic [psp_pkg::PRIO_W-1:0] np);
      psp_pkg::psp_res_t r;
      int best_prio;
      logic [15:0] best_sl;
      int best;
      bit live;
      r = '0;
      live = used[s];
      ops_seen++;
      case (op)
        psp_pkg::OP_ALLOC: begin
          used[s] = 1'b1;
          runnable[s] = 1'b0;
          prio[s] = init_prio;
          slices[s] = '0;
          r.found = 1'b1;
          r.status = psp_pkg::ST_OK;
        end
        psp_pkg::OP_RUN, psp_pkg::OP_STOP, psp_pkg::OP_FREE: begin
          if (!live) begin
            r.status = psp_pkg::ST_NONE;
          end else begin
            runnable[s] = (op == psp_pkg::OP_RUN);
            if (op == psp_pkg::OP_FREE) used[s] = 1'b0;
            r.found = 1'b1;
            r.status = psp_pkg::ST_OK;
          end
        end
        psp_pkg::OP_SETPRI: begin
          // range check comes before the slot check
          if (np > psp_pkg::PRIO_MAX) begin
            r.status = psp_pkg::ST_RANGE;
            range_rejects++;
          end else if (!live) begin
            r.status = psp_pkg::ST_NONE;
          end else begin
            r.old_priority = prio[s];
            if (prio[s] != np) slices[s] = '0;
            prio[s] = np;
            r.found = 1'b1;
            r.status = psp_pkg::ST_OK;
          end
        end
        psp_pkg::OP_PICK: begin
          // lowest priority, then fewest slices, then lowest index
          best_prio = PRIO_NONE;
          best_sl = '0;
          best = -1;
          for (int i = 0; i < NSLOT; i++) begin
            if (used[i] && runnable[i]) begin
              if (int'(prio[i]) < best_prio ||
                  (int'(prio[i]) == best_prio && slices[i] < best_sl)) begin
                best_prio = int'(prio[i]);
                best_sl = slices[i];
                best = i;
              end
            end
          end
          if (best < 0) begin
            r.status = psp_pkg::ST_NONE;
          end else begin
            if (slices[best] != SLICE_TOP) slices[best] = slices[best] + 16'd1;
            runnable[best] = 1'b0;
            r.found = 1'b1;
            r.chosen_slot = best[psp_pkg::SLOT_W-1:0];
            r.status = psp_pkg::ST_OK;
            picks_hit++;
          end
        end
        default: begin
          // undefined op: all fields stay zero
        end
      endcase
      awaited_res.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(psp_pkg::psp_res_t got);
      psp_pkg::psp_res_t want;
      if (awaited_res.size() == 0) begin
        $display("%0t: result with nothing awaited: found %0d slot %0d old %0d status %0d",
                 $time, got.found, got.chosen_slot, got.old_priority, got.status);
        errors++;
        return;
      end
      want = awaited_res.pop_front();
      checked++;
      if (got.found !== want.found) begin
        $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.chosen_slot !== want.chosen_slot) begin
        $display("%0t: chosen_slot expected %0d actual %0d", $time, want.chosen_slot,
                 got.chosen_slot);
        errors++;
      end
      if (got.old_priority !== want.old_priority) begin
        $display("%0t: old_priority expected %0d actual %0d", $time, want.old_priority,
                 got.old_priority);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   hot_base;
  int   hot_size;
  sched_board sb = new();

  psp_cfg_if cfg_ch ();
  psp_in_if  in_ch ();
  psp_out_if out_ch ();

  priority_slice_picker_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    psp_pkg::psp_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.found = out_ch.found;
      got.chosen_slot = out_ch.chosen_slot;
      got.old_priority = out_ch.old_priority;
      got.status = out_ch.status;
      sb.check_result(got);
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // present one op and hold it until the transfer
  task automatic send_op(logic [psp_pkg::OP_W-1:0] op, logic [psp_pkg::SLOT_W-1:0] s,
                         logic [psp_pkg::PRIO_W-1:0] np);
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.slot <= s;
    in_ch.req_prio <= np;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(op, s, np);
  endtask

  // optional sender gap before the next op
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic write_initial(logic [psp_pkg::PRIO_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_initial(v);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random op: mostly on a small window of slots so the table fills up
  task automatic random_op(output bit counted);
    int r;
    logic [psp_pkg::OP_W-1:0] op;
    logic [psp_pkg::SLOT_W-1:0] s;
    logic [psp_pkg::PRIO_W-1:0] np;
    r = $urandom_range(0, 99);
    if (r < 15) op = psp_pkg::OP_ALLOC;
    else if (r < 40) op = psp_pkg::OP_RUN;
    else if (r < 47) op = psp_pkg::OP_STOP;
    else if (r < 53) op = psp_pkg::OP_FREE;
    else if (r < 67) op = psp_pkg::OP_SETPRI;
    else if (r < 97) op = psp_pkg::OP_PICK;
    else op = psp_pkg::OP_W'($urandom_range(6, 7));
    if ($urandom_range(0, 3) != 0) begin
      s = psp_pkg::SLOT_W'(hot_base + $urandom_range(0, hot_size - 1));
    end else begin
      s = psp_pkg::SLOT_W'($urandom_range(0, NSLOT - 1));
    end
    r = $urandom_range(0, 99);
    if (r < 10) np = psp_pkg::PRIO_W'($urandom_range(101, 127));
    else if (r < 30) np = psp_pkg::PRIO_W'($urandom_range(0, 100));
    else begin
      case ($urandom_range(0, 3))
        0: np = 7'd0;
        1: np = 7'd7;
        2: np = sb.init_prio;
        default: np = psp_pkg::PRIO_MAX;
      endcase
    end
    maybe_gap();
    send_op(op, s, np);
    counted = (op <= psp_pkg::OP_PICK);
  endtask

  // stimulus
  initial begin
    int done;
    bit counted;
    logic [psp_pkg::PRIO_W-1:0] cfg_val;
    rst_n <= 1'b0;
    calm = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= psp_pkg::OP_ALLOC;
    in_ch.slot <= '0;
    in_ch.req_prio <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, register still at its reset value
    send_op(psp_pkg::OP_PICK, 6'd0, 7'd0);          // nothing runnable
    send_op(psp_pkg::OP_ALLOC, 6'd0, 7'd0);
    send_op(psp_pkg::OP_ALLOC, 6'd63, 7'd127);
    send_op(psp_pkg::OP_SETPRI, 6'd63, 7'd127);     // out of range on a used slot
    send_op(psp_pkg::OP_SETPRI, 6'd5, 7'd101);      // out of range wins over unused slot
    send_op(psp_pkg::OP_SETPRI, 6'd5, 7'd100);      // unused slot
    maybe_gap();
    send_op(psp_pkg::OP_RUN, 6'd5, 7'd0);
    send_op(psp_pkg::OP_STOP, 6'd5, 7'd0);
    send_op(psp_pkg::OP_FREE, 6'd5, 7'd0);
    send_op(psp_pkg::OP_SETPRI, 6'd63, psp_pkg::PRIO_MAX);  // returns the reset priority
    send_op(psp_pkg::OP_SETPRI, 6'd0, psp_pkg::PRIO_RESET); // same value keeps slices
    send_op(psp_pkg::OP_RUN, 6'd0, 7'd0);
    send_op(psp_pkg::OP_RUN, 6'd63, 7'd0);
    send_op(psp_pkg::OP_PICK, 6'd63, 7'd0);
    send_op(psp_pkg::OP_PICK, 6'd0, 7'd0);
    send_op(psp_pkg::OP_PICK, 6'd0, 7'd0);
    maybe_gap();
    send_op(psp_pkg::OP_RUN, 6'd0, 7'd0);
    send_op(psp_pkg::OP_ALLOC, 6'd1, 7'd0);
    send_op(psp_pkg::OP_RUN, 6'd1, 7'd0);
    send_op(psp_pkg::OP_PICK, 6'd0, 7'd0);          // tie on priority, fewer slices wins
    send_op(psp_pkg::OP_ALLOC, 6'd0, 7'd0);         // reinitialise a used slot
    send_op(3'd6, 6'd63, 7'd127);
    send_op(3'd7, 6'd42, 7'd85);
    send_op(psp_pkg::OP_FREE, 6'd63, 7'd0);
    send_op(psp_pkg::OP_RUN, 6'd63, 7'd0);          // freed slot
    send_op(psp_pkg::OP_SETPRI, 6'd0, 7'd0);
    send_op(psp_pkg::OP_RUN, 6'd0, 7'd0);
    send_op(psp_pkg::OP_STOP, 6'd1, 7'd0);
    send_op(psp_pkg::OP_PICK, 6'd0, 7'd0);
    wait_drained();

    // random phases, each with its own register setting
    for (int ph = 0; ph < NPHASE; ph++) begin
      case (ph)
        0: cfg_val = 7'd0;
        1: cfg_val = psp_pkg::PRIO_MAX;
        2: cfg_val = 7'd127;
        3: cfg_val = 7'd101;
        default: cfg_val = psp_pkg::PRIO_W'($urandom_range(0, 127));
      endcase
      write_initial(cfg_val);
      hot_size = $urandom_range(3, 12);
      hot_base = $urandom_range(0, NSLOT - hot_size);
      calm = (ph == NPHASE - 1);
      done = 0;
      while (done < PHASE_OPS) begin
        random_op(counted);
        if (counted) done++;
      end
      wait_drained();
    end

    repeat (80) @(posedge clk);
    $display("ran %0d ops over %0d register settings, %0d results checked",
             sb.ops_seen, NPHASE + 1, sb.checked);
    $display("%0d picks chose a slot, %0d priority writes rejected as out of range",
             sb.picks_hit, sb.range_rejects);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout at %0t with %0d results awaited", $time, sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
